/* hw/rtl/greedy_meshlet_partitioner_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the greedy meshlet partitioner
// Clocked assertion helpers; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef GREEDY_MESHLET_PARTITIONER_ASSERT_SVH
`define GREEDY_MESHLET_PARTITIONER_ASSERT_SVH
`ifndef SYNTHESIS
// property holds at every edge outside reset
`define GMP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent at one edge implies consequent at the next
`define GMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GMP_ASSERT(lbl, clk, rst_n, prop, msg)
`define GMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/gmp_pkg.sv */
// ----------------------------------------------------------------------------
// gmp_pkg
// Types and constants shared by the greedy meshlet partitioner.
// ----------------------------------------------------------------------------
package gmp_pkg;

	localparam int MAX_VERTS_DEF = 64;
	localparam int MAX_TRIS_DEF  = 128;

	localparam int GIDX_W  = 20;   // global vertex index
	localparam int WORD_W  = 32;   // map entries, offsets
	localparam int LOCAL_W = 8;    // local corner number
	localparam int CNT_W   = 9;    // vertex / triangle count

	// result kinds
	localparam logic [1:0] KIND_MAP    = 2'd0;
	localparam logic [1:0] KIND_TRIPLE = 2'd1;
	localparam logic [1:0] KIND_DESC   = 2'd2;

	typedef struct packed {
		logic [GIDX_W-1:0] corner_a;
		logic [GIDX_W-1:0] corner_b;
		logic [GIDX_W-1:0] corner_c;
		logic              final_triangle;
	} tri_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [WORD_W-1:0]  map_entry;
		logic [LOCAL_W-1:0] local_a;
		logic [LOCAL_W-1:0] local_b;
		logic [LOCAL_W-1:0] local_c;
		logic [WORD_W-1:0]  vertex_offset;
		logic [CNT_W-1:0]   vertex_count;
		logic [WORD_W-1:0]  index_offset;
		logic [CNT_W-1:0]   triangle_count;
		logic               run_end;
	} res_item_t;

endpackage

/* hw/rtl/greedy_meshlet_partitioner.sv */
// ----------------------------------------------------------------------------
// greedy_meshlet_partitioner
// Packs a triangle stream greedily into meshlets and emits vertex map
// entries, local index triples and meshlet descriptors.
// ----------------------------------------------------------------------------
// Triangles are taken into an input register and handled there: the three
// corners are looked up in parallel in a small CAM of the open meshlet's
// global indices (MAX_VERTS entries, valid below the open vertex count, so
// nothing to clear after reset), the limit check decides whether the open
// meshlet closes first, and all results of the triangle (closing descriptor,
// up to three map entries, the index triple, final descriptor) are written at
// once into a result bundle register. The bundle drains through the single
// result port one result per cycle while res_ready is high, and the next
// triangle is handled in the cycle its last result goes out. A triangle has
// one result in the usual case and up to six. With the block idle, the first
// result is presented from the result bundle register once the request has
// passed through the input register. base_vertex is written through cfg_we /
// cfg_wdata; the user must write it only while the block is idle, as the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "greedy_meshlet_partitioner_assert.svh"

module greedy_meshlet_partitioner #(
	parameter int MAX_VERTS = gmp_pkg::MAX_VERTS_DEF,
	parameter int MAX_TRIS  = gmp_pkg::MAX_TRIS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tri_valid,
	output logic                       tri_ready,
	input  gmp_pkg::tri_item_t         tri_data,
	output logic                       res_valid,
	input  logic                       res_ready,
	output gmp_pkg::res_item_t         res_data,
	input  logic                       cfg_we,
	input  logic [gmp_pkg::WORD_W-1:0] cfg_wdata
);

	localparam int SLOT_W = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
	localparam int CW     = gmp_pkg::CNT_W;
	localparam int WW     = gmp_pkg::WORD_W;
	localparam int LW     = gmp_pkg::LOCAL_W;
	localparam int GW     = gmp_pkg::GIDX_W;
	localparam logic [CW:0] MAX_V_L = (CW+1)'(MAX_VERTS);
	localparam logic [CW:0] MAX_T_L = (CW+1)'(MAX_TRIS);

	// bundle slot order = result order
	localparam int B_CLOSE  = 0;
	localparam int B_MAP_A  = 1;
	localparam int B_MAP_B  = 2;
	localparam int B_MAP_C  = 3;
	localparam int B_TRIPLE = 4;
	localparam int B_FINAL  = 5;
	localparam int B_N      = 6;

	// ---------------- state ----------------
	logic [WW-1:0] base_q;
	logic [CW-1:0] ov_q;          // open vertices
	logic [CW-1:0] ot_q;          // open triangles
	logic [WW-1:0] mt_q;          // map total of closed meshlets
	logic [WW-1:0] it_q;          // index total of closed meshlets
	logic [GW-1:0] slot_q [MAX_VERTS];   // CAM, valid below ov_q

	// input register
	logic               item_vld_s1;
	gmp_pkg::tri_item_t item_s1;

	// result bundle
	logic [B_N-1:0] pres_q;
	logic [WW-1:0]  cl_mt_q, cl_it_q, fn_mt_q, fn_it_q;
	logic [CW-1:0]  cl_ov_q, cl_ot_q, fn_ov_q, fn_ot_q;
	logic [WW-1:0]  map_q [3];
	logic [LW-1:0]  loc_q [3];

	// ---------------- output selection ----------------
	logic [B_N-1:0] sel;
	logic           run_end;
	logic           res_take;
	logic           process;

	assign sel       = pres_q & (~pres_q + B_N'(1));   // lowest pending result
	assign run_end   = (pres_q & ~sel) == '0;
	assign res_valid = |pres_q;
	assign res_take  = res_valid && res_ready;
	// handle the held triangle once the bundle is empty or emptying
	assign process   = item_vld_s1 && ((pres_q == '0) || (res_take && run_end));
	assign tri_ready = !item_vld_s1 || process;

	always_comb begin
		res_data         = '0;
		res_data.run_end = run_end;
		if (sel[B_CLOSE]) begin
			res_data.kind           = gmp_pkg::KIND_DESC;
			res_data.vertex_offset  = cl_mt_q;
			res_data.vertex_count   = cl_ov_q;
			res_data.index_offset   = cl_it_q;
			res_data.triangle_count = cl_ot_q;
		end else if (sel[B_MAP_A]) begin
			res_data.kind      = gmp_pkg::KIND_MAP;
			res_data.map_entry = map_q[0];
		end else if (sel[B_MAP_B]) begin
			res_data.kind      = gmp_pkg::KIND_MAP;
			res_data.map_entry = map_q[1];
		end else if (sel[B_MAP_C]) begin
			res_data.kind      = gmp_pkg::KIND_MAP;
			res_data.map_entry = map_q[2];
		end else if (sel[B_TRIPLE]) begin
			res_data.kind    = gmp_pkg::KIND_TRIPLE;
			res_data.local_a = loc_q[0];
			res_data.local_b = loc_q[1];
			res_data.local_c = loc_q[2];
		end else if (sel[B_FINAL]) begin
			res_data.kind           = gmp_pkg::KIND_DESC;
			res_data.vertex_offset  = fn_mt_q;
			res_data.vertex_count   = fn_ov_q;
			res_data.index_offset   = fn_it_q;
			res_data.triangle_count = fn_ot_q;
		end
	end

	// ---------------- CAM lookup ----------------
	logic [MAX_VERTS-1:0] m_a, m_b, m_c;
	logic [SLOT_W-1:0]    idx_a, idx_b, idx_c;
	logic                 hit_a, hit_b, hit_c;

	always_comb begin
		idx_a = '0;
		idx_b = '0;
		idx_c = '0;
		for (int i = 0; i < MAX_VERTS; i++) begin
			m_a[i] = (CW'(i) < ov_q) && (slot_q[i] == item_s1.corner_a);
			m_b[i] = (CW'(i) < ov_q) && (slot_q[i] == item_s1.corner_b);
			m_c[i] = (CW'(i) < ov_q) && (slot_q[i] == item_s1.corner_c);
			// live entries are distinct, so at most one match: OR-encode
			idx_a = idx_a | (m_a[i] ? SLOT_W'(i) : '0);
			idx_b = idx_b | (m_b[i] ? SLOT_W'(i) : '0);
			idx_c = idx_c | (m_c[i] ? SLOT_W'(i) : '0);
		end
		hit_a = |m_a;
		hit_b = |m_b;
		hit_c = |m_c;
	end

	// ---------------- limit check and local numbering ----------------
	logic [1:0]    fresh;         // repeated new corners count twice here
	logic          close_first;
	logic          eh_a, eh_b, eh_c;
	logic          new_a, new_b, new_c;
	logic          dup_ba, dup_ca, dup_cb;
	logic [CW-1:0] nv0, pos_a, pos_b, pos_c, ov1, ot1;
	logic [LW-1:0] loc_a, loc_b, loc_c;
	logic [WW-1:0] mt_c, it_c, tri3_q, tri3_1;

	always_comb begin
		fresh = 2'({1'b0, !hit_a} + {1'b0, !hit_b}) + 2'({1'b0, !hit_c});
		close_first = (((CW+1)'(ov_q) + (CW+1)'(fresh)) > MAX_V_L ||
			((CW+1)'(ot_q) + (CW+1)'(1)) > MAX_T_L) && (ot_q != '0);

		// after an early close the table is empty: nothing hits
		eh_a = hit_a && !close_first;
		eh_b = hit_b && !close_first;
		eh_c = hit_c && !close_first;
		nv0  = close_first ? '0 : ov_q;

		new_a  = !eh_a;
		dup_ba = new_a && (item_s1.corner_b == item_s1.corner_a);
		new_b  = !eh_b && !dup_ba;
		dup_ca = new_a && (item_s1.corner_c == item_s1.corner_a);
		dup_cb = new_b && (item_s1.corner_c == item_s1.corner_b);
		new_c  = !eh_c && !dup_ca && !dup_cb;

		pos_a = nv0;
		pos_b = pos_a + CW'(new_a);
		pos_c = pos_b + CW'(new_b);
		ov1   = pos_c + CW'(new_c);
		ot1   = (close_first ? '0 : ot_q) + CW'(1);

		loc_a = eh_a ? LW'(idx_a) : pos_a[LW-1:0];
		if (eh_b)
			loc_b = LW'(idx_b);
		else if (dup_ba)
			loc_b = loc_a;
		else
			loc_b = pos_b[LW-1:0];
		if (eh_c)
			loc_c = LW'(idx_c);
		else if (dup_ca)
			loc_c = loc_a;
		else if (dup_cb)
			loc_c = loc_b;
		else
			loc_c = pos_c[LW-1:0];

		tri3_q = WW'(ot_q) + WW'({ot_q, 1'b0});
		tri3_1 = WW'(ot1) + WW'({ot1, 1'b0});
		mt_c   = close_first ? mt_q + WW'(ov_q) : mt_q;
		it_c   = close_first ? it_q + tri3_q : it_q;
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			ov_q        <= '0;
			ot_q        <= '0;
			mt_q        <= '0;
			it_q        <= '0;
			item_vld_s1 <= 1'b0;
			pres_q      <= '0;
		end else begin
			if (cfg_we)
				base_q <= cfg_wdata;

			if (tri_ready)
				item_vld_s1 <= tri_valid;

			if (process) begin
				pres_q <= {item_s1.final_triangle, 1'b1, new_c, new_b, new_a, close_first};
				if (item_s1.final_triangle) begin
					ov_q <= '0;
					ot_q <= '0;
					mt_q <= mt_c + WW'(ov1);
					it_q <= it_c + tri3_1;
				end else begin
					ov_q <= ov1;
					ot_q <= ot1;
					mt_q <= mt_c;
					it_q <= it_c;
				end
			end else if (res_take) begin
				pres_q <= pres_q & ~sel;
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (tri_ready && tri_valid)
			item_s1 <= tri_data;

		if (process) begin
			cl_mt_q  <= mt_q;
			cl_ov_q  <= ov_q;
			cl_it_q  <= it_q;
			cl_ot_q  <= ot_q;
			fn_mt_q  <= mt_c;
			fn_ov_q  <= ov1;
			fn_it_q  <= it_c;
			fn_ot_q  <= ot1;
			map_q[0] <= base_q + WW'(item_s1.corner_a);
			map_q[1] <= base_q + WW'(item_s1.corner_b);
			map_q[2] <= base_q + WW'(item_s1.corner_c);
			loc_q[0] <= loc_a;
			loc_q[1] <= loc_b;
			loc_q[2] <= loc_c;
		end

		// new corners take the next free slots
		for (int i = 0; i < MAX_VERTS; i++) begin
			if (process && new_a && pos_a[SLOT_W-1:0] == SLOT_W'(i))
				slot_q[i] <= item_s1.corner_a;
			if (process && new_b && pos_b[SLOT_W-1:0] == SLOT_W'(i))
				slot_q[i] <= item_s1.corner_b;
			if (process && new_c && pos_c[SLOT_W-1:0] == SLOT_W'(i))
				slot_q[i] <= item_s1.corner_c;
		end
	end

	// ---------------- assertions ----------------
	`GMP_ASSERT(a_vert_limit, clk, arst_n, ov_q <= CW'(MAX_VERTS), "open vertex count over limit")
	`GMP_ASSERT(a_tri_limit, clk, arst_n, (CW+1)'(ot_q) <= MAX_T_L, "open triangle count over limit")
	`GMP_ASSERT(a_empty_mesh, clk, arst_n, (ot_q != '0) || (ov_q == '0), "vertices without triangles")
	`GMP_ASSERT_NEXT(a_triple_out, clk, arst_n, process, pres_q[B_TRIPLE], "triple not queued")

endmodule

/* sim/greedy_meshlet_partitioner_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_meshlet_partitioner_tb
// Streams triangle requests into the partitioner and checks each result, in
// order and field by field, against a cycle-free model of the meshlet packer.
// ----------------------------------------------------------------------------
module greedy_meshlet_partitioner_tb;
	import gmp_pkg::*;

	localparam int MESH_VERTS    = MAX_VERTS_DEF;
	localparam int MESH_TRIS     = MAX_TRIS_DEF;
	localparam int CORNERS       = 3;      // corners per triangle, local indices per triple
	localparam int SETTLE_CYCLES = 8;      // settling time after the last owed result
	localparam int CYCLE_LIMIT   = 200000;
	localparam int IDLE_PCT      = 23;
	localparam int POOL_SIZE     = 30;     // below MESH_VERTS: corners keep hitting the table
	localparam int POOL_TRIS     = 30;
	localparam int NOISE_POOL    = 6;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              tri_valid = 1'b0;
	logic              tri_ready;
	tri_item_t         tri_data  = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	res_item_t         res_data;
	logic              cfg_we    = 1'b0;
	logic [WORD_W-1:0] cfg_wdata = '0;
	logic              quiet     = 1'b0;   // no idling on either side while set
	int unsigned       cycles    = 0;

	// ------------------------------------------------------------------------
	// Meshlet tracker: own copy of the packer state, the queue of results still
	// owed by the block, and the comparison of what comes out.
	// ------------------------------------------------------------------------
	class meshlet_tracker;
		logic [WORD_W-1:0] base;
		logic [GIDX_W-1:0] slot_vertex [MESH_VERTS];
		int                open_verts;
		int                open_tris;
		logic [WORD_W-1:0] map_total;
		logic [WORD_W-1:0] index_total;
		res_item_t         owed [$];
		int                errors;

		function new();
			base        = '0;
			open_verts  = 0;
			open_tris   = 0;
			map_total   = '0;
			index_total = '0;
			errors      = 0;
		endfunction

		// append to the tail of the owed queue
		function void queue_result(res_item_t r);
			owed = {owed, r};
		endfunction

		// local number of a global index in the open meshlet, -1 if absent
		function int find_slot(logic [GIDX_W-1:0] g);
			for (int i = 0; i < open_verts; i++)
				if (slot_vertex[i] == g)
					return i;
			return -1;
		endfunction

		function void close_meshlet();
			res_item_t r;
			r                = '0;
			r.kind           = KIND_DESC;
			r.vertex_offset  = map_total;
			r.vertex_count   = CNT_W'(open_verts);
			r.index_offset   = index_total;
			r.triangle_count = CNT_W'(open_tris);
			queue_result(r);
			map_total   = map_total + WORD_W'(open_verts);
			index_total = index_total + WORD_W'(CORNERS * open_tris);
			open_verts  = 0;
			open_tris   = 0;
		endfunction

		// work out every result an accepted request causes
		function void note_triangle(tri_item_t t);
			logic [GIDX_W-1:0]  c   [CORNERS];
			logic [LOCAL_W-1:0] loc [CORNERS];
			int                 fresh;
			int                 s;
			res_item_t          r;
			c[0]  = t.corner_a;
			c[1]  = t.corner_b;
			c[2]  = t.corner_c;
			fresh = 0;
			// a repeated new corner is counted twice here on purpose
			for (int i = 0; i < CORNERS; i++)
				if (find_slot(c[i]) < 0)
					fresh++;
			// never close an empty meshlet
			if ((open_verts + fresh > MESH_VERTS || open_tris + 1 > MESH_TRIS) && open_tris > 0)
				close_meshlet();
			for (int i = 0; i < CORNERS; i++) begin
				s = find_slot(c[i]);
				if (s < 0 && open_verts < MESH_VERTS) begin
					slot_vertex[open_verts] = c[i];
					s = open_verts;
					open_verts++;
					r           = '0;
					r.kind      = KIND_MAP;
					r.map_entry = base + WORD_W'(c[i]);
					queue_result(r);
				end
				loc[i] = (s < 0) ? '0 : LOCAL_W'(s);
			end
			r         = '0;
			r.kind    = KIND_TRIPLE;
			r.local_a = loc[0];
			r.local_b = loc[1];
			r.local_c = loc[2];
			queue_result(r);
			open_tris++;
			if (t.final_triangle)
				close_meshlet();
			// mark the last result of this request
			r         = owed.pop_back();
			r.run_end = 1'b1;
			queue_result(r);
		endfunction

		function void compare(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(res_item_t got);
			res_item_t want;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, expected none, actual %h",
					$time, got);
				return;
			end
			want = owed.pop_front();
			compare("kind", WORD_W'(want.kind), WORD_W'(got.kind));
			compare("map_entry", want.map_entry, got.map_entry);
			compare("local_a", WORD_W'(want.local_a), WORD_W'(got.local_a));
			compare("local_b", WORD_W'(want.local_b), WORD_W'(got.local_b));
			compare("local_c", WORD_W'(want.local_c), WORD_W'(got.local_c));
			compare("vertex_offset", want.vertex_offset, got.vertex_offset);
			compare("vertex_count", WORD_W'(want.vertex_count), WORD_W'(got.vertex_count));
			compare("index_offset", want.index_offset, got.index_offset);
			compare("triangle_count", WORD_W'(want.triangle_count),
				WORD_W'(got.triangle_count));
			compare("run_end", WORD_W'(want.run_end), WORD_W'(got.run_end));
		endfunction
	endclass

	meshlet_tracker tracker;

	greedy_meshlet_partitioner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tri_valid (tri_valid),
		.tri_ready (tri_ready),
		.tri_data  (tri_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// handshakes are sampled with pre-edge values, so no race with the block
	always @(posedge clk) begin
		if (arst_n) begin
			if (tri_valid && tri_ready)
				tracker.note_triangle(tri_data);
			if (res_valid && res_ready)
				tracker.check_result(res_data);
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		res_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic tri_item_t make_tri(logic [GIDX_W-1:0] a, logic [GIDX_W-1:0] b,
		logic [GIDX_W-1:0] c, logic fin);
		tri_item_t t;
		t.corner_a       = a;
		t.corner_b       = b;
		t.corner_c       = c;
		t.final_triangle = fin;
		return t;
	endfunction

	// offer one request, with random idle cycles in front; valid stays high
	// on return so back-to-back requests need no extra edge
	task automatic send_triangle(tri_item_t t);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			tri_valid <= 1'b0;
			@(posedge clk);
		end
		tri_valid <= 1'b1;
		tri_data  <= t;
		do @(posedge clk); while (!tri_ready);
	endtask

	// hold off until every owed result is out and the block has settled;
	// the first edge lets the monitor see the last accepted request
	task automatic drain();
		tri_valid <= 1'b0;
		@(posedge clk);
		while (tracker.owed.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic write_base(logic [WORD_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we       <= 1'b0;
		tracker.base  = v;
	endtask

	initial begin : stimulus
		logic [GIDX_W-1:0] pool  [POOL_SIZE];
		logic [GIDX_W-1:0] noise [NOISE_POOL];
		logic [GIDX_W-1:0] prev  [CORNERS];
		logic [GIDX_W-1:0] v     [CORNERS];
		int                pick;

		tracker = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: extremes, repeated corners, wrap of the map entry ---
		write_base('1);
		send_triangle(make_tri('0, '0, '0, 1'b0));              // one corner three times
		send_triangle(make_tri('1, '1, 20'd1, 1'b0));           // repeated new corner
		send_triangle(make_tri('0, 20'd1, '1, 1'b0));           // all corners already seen
		send_triangle(make_tri(20'd2, 20'd3, 20'd4, 1'b1));     // final closes meshlet
		send_triangle(make_tri(20'h55555, 20'hAAAAA, 20'h55555, 1'b1)); // one-triangle meshlet
		drain();

		// --- directed: vertex limit, with a repeated corner counted twice ---
		write_base('0);
		for (int k = 0; k < 20; k++)
			send_triangle(make_tri(GIDX_W'(1000 + 3 * k), GIDX_W'(1001 + 3 * k),
				GIDX_W'(1002 + 3 * k), 1'b0));
		send_triangle(make_tri(20'd5000, 20'd5000, 20'd5001, 1'b0)); // 60 + 3 fits
		send_triangle(make_tri(20'd6000, 20'd6000, 20'd6001, 1'b0)); // 62 + 3 closes first
		send_triangle(make_tri(20'd6001, 20'd6002, 20'd6000, 1'b1));
		drain();

		// --- random: mostly fresh corners, reaches the vertex limit ---
		write_base($urandom());
		for (int i = 0; i < CORNERS; i++)
			prev[i] = GIDX_W'($urandom());
		for (int k = 0; k < 32; k++) begin
			for (int i = 0; i < CORNERS; i++)
				v[i] = ($urandom_range(99) < 70) ? GIDX_W'($urandom())
					: prev[$urandom_range(CORNERS - 1)];
			prev = v;
			send_triangle(make_tri(v[0], v[1], v[2], $urandom_range(99) < 2));
		end
		drain();

		// --- random: small vertex set, mostly hits in the open meshlet ---
		write_base(32'hFFFFF000);
		pool[0] = '0;
		pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			pool[i] = GIDX_W'($urandom());
		quiet <= 1'b1;
		for (int k = 0; k < POOL_TRIS; k++) begin
			if (k == 24)
				quiet <= 1'b0;
			send_triangle(make_tri(pool[$urandom_range(POOL_SIZE - 1)],
				pool[$urandom_range(POOL_SIZE - 1)], pool[$urandom_range(POOL_SIZE - 1)],
				k == POOL_TRIS - 1));
		end
		drain();

		// --- random: noise, frequent finals, a full stop half way ---
		write_base($urandom());
		for (int i = 0; i < NOISE_POOL; i++)
			noise[i] = GIDX_W'($urandom());
		for (int k = 0; k < 24; k++) begin
			if (k == 12)
				drain();
			for (int i = 0; i < CORNERS; i++) begin
				pick = $urandom_range(99);
				if (pick < 50)
					v[i] = noise[$urandom_range(NOISE_POOL - 1)];
				else if (pick < 80 || i == 0)
					v[i] = GIDX_W'($urandom());
				else
					v[i] = v[i - 1];
			end
			send_triangle(make_tri(v[0], v[1], v[2], $urandom_range(99) < 15));
		end
		drain();

		if (tracker.errors == 0 && tracker.owed.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/gmp_pkg.sv
hw/rtl/greedy_meshlet_partitioner.sv
sim/greedy_meshlet_partitioner_tb.sv
